// File: src/qmic_pkg.sv
// Shared constants, types and codes for the Morton index codec.
`timescale 1ns / 1ps
package qmic_pkg;

  localparam int COORD_BITS    = 30;
  localparam int INDEX_BITS    = 60;
  localparam int LEVEL_W       = 5;
  localparam int ERR_W         = 3;
  localparam int NUM_AXES      = 3;
  localparam int DIMENSION_DEF = 2;
  localparam int LEVEL_CAP_DEF = 30;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [INDEX_BITS-1:0] idx_t;
  typedef logic [LEVEL_W-1:0]    level_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 3'd0,
    ERR_LEVEL = 3'd1,
    ERR_ALIGN = 3'd2,
    ERR_ROOT  = 3'd3,
    ERR_INDEX = 3'd4
  } err_t;

  // Request as unpacked from the input word.
  typedef struct packed {
    logic                  req;
    level_t                tlev;
    level_t                clev;
    coord_t [NUM_AXES-1:0] coord;
    idx_t                  idx;
  } req_t;

  // After the checking stage.
  typedef struct packed {
    logic                  req;
    level_t                tlev;
    coord_t [NUM_AXES-1:0] coord;
    idx_t                  idx;
    err_t                  err;
  } chk_t;

  // After the alignment stage: per-axis level bits, right aligned.
  typedef struct packed {
    logic                  req;
    level_t                tlev;
    coord_t [NUM_AXES-1:0] bits;
    err_t                  err;
  } aln_t;

  // Result item.
  typedef struct packed {
    idx_t                  index;
    coord_t [NUM_AXES-1:0] coord;
    level_t                level;
    err_t                  err;
  } res_t;

endpackage

// File: src/qmic_check.sv
// First stage: validates levels, alignment and the index bound.
`timescale 1ns / 1ps
module qmic_check #(
  parameter int DIMENSION = qmic_pkg::DIMENSION_DEF,
  parameter int LEVEL_CAP = qmic_pkg::LEVEL_CAP_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qmic_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qmic_pkg::chk_t  out_data
);
  import qmic_pkg::*;

  localparam coord_t COORD_ONES = '1;

  chk_t       chk_next;
  coord_t     low;
  logic       misal;
  logic [6:0] nbits;
  logic       tlev_ok;

  always_comb begin
    low   = COORD_ONES >> in_data.clev;
    misal = 1'b0;
    for (int d = 0; d < NUM_AXES; d++) begin
      if (d < DIMENSION) begin
        chk_next.coord[d] = in_data.coord[d];
        misal = misal | (|(in_data.coord[d] & low));
      end else begin
        chk_next.coord[d] = '0;
      end
    end
    nbits   = 7'(DIMENSION) * {2'b00, in_data.tlev};
    tlev_ok = (in_data.tlev <= LEVEL_W'(LEVEL_CAP)) && (nbits <= 7'(INDEX_BITS));
    chk_next.req  = in_data.req;
    chk_next.tlev = in_data.tlev;
    chk_next.idx  = in_data.idx;
    priority if (!in_data.req) begin
      priority if (in_data.clev > LEVEL_W'(LEVEL_CAP)) chk_next.err = ERR_LEVEL;
      else if (misal)                                 chk_next.err = ERR_ALIGN;
      else if (!tlev_ok)                              chk_next.err = ERR_LEVEL;
      else                                            chk_next.err = ERR_OK;
    end else begin
      priority if (!tlev_ok)                          chk_next.err = ERR_LEVEL;
      else if ((in_data.idx >> nbits) != '0)          chk_next.err = ERR_INDEX;
      else                                            chk_next.err = ERR_OK;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= chk_next;
    end
  end

  // Coordinates always fit the root, so that code never appears.
  a_no_root: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.err != ERR_ROOT)
    else $error("outside-root code produced");

  // The index bound only applies to decode requests.
  a_index_decode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.err == ERR_INDEX |-> out_data.req)
    else $error("index error on an encode request");

endmodule

// File: src/qmic_align.sv
// Second stage: extracts the level bits of each axis, right aligned.
`timescale 1ns / 1ps
module qmic_align #(
  parameter int DIMENSION = qmic_pkg::DIMENSION_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qmic_pkg::chk_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qmic_pkg::aln_t  out_data
);
  import qmic_pkg::*;

  aln_t   aln_next;
  level_t shift;
  int     p;

  always_comb begin
    p     = 0;
    shift = LEVEL_W'(COORD_BITS) - in_data.tlev;
    for (int d = 0; d < NUM_AXES; d++) begin
      aln_next.bits[d] = '0;
    end
    if (!in_data.req) begin
      for (int d = 0; d < NUM_AXES; d++) begin
        aln_next.bits[d] = in_data.coord[d] >> shift;
      end
    end else begin
      // Bits above the level are zero once the bound check passed.
      for (int i = 0; i < COORD_BITS; i++) begin
        for (int d = 0; d < DIMENSION; d++) begin
          p = DIMENSION * i + d;
          if (p < INDEX_BITS) begin
            aln_next.bits[d][i] = in_data.idx[p[5:0]];
          end
        end
      end
    end
    aln_next.req  = in_data.req;
    aln_next.tlev = in_data.tlev;
    aln_next.err  = in_data.err;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= aln_next;
    end
  end

endmodule

// File: src/qmic_pack.sv
// Third stage: interleaves or realigns, forms the result register.
`timescale 1ns / 1ps
module qmic_pack #(
  parameter int DIMENSION = qmic_pkg::DIMENSION_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  qmic_pkg::aln_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output qmic_pkg::res_t  out_data
);
  import qmic_pkg::*;

  res_t   res_next;
  level_t shift;
  int     p;

  always_comb begin
    p              = 0;
    shift          = LEVEL_W'(COORD_BITS) - in_data.tlev;
    res_next.index = '0;
    res_next.level = '0;
    res_next.err   = in_data.err;
    for (int d = 0; d < NUM_AXES; d++) begin
      res_next.coord[d] = '0;
    end
    if (in_data.err == ERR_OK) begin
      if (!in_data.req) begin
        for (int i = 0; i < COORD_BITS; i++) begin
          for (int d = 0; d < DIMENSION; d++) begin
            p = DIMENSION * i + d;
            if (p < INDEX_BITS) begin
              res_next.index[p[5:0]] = in_data.bits[d][i];
            end
          end
        end
      end else begin
        for (int d = 0; d < NUM_AXES; d++) begin
          res_next.coord[d] = in_data.bits[d] << shift;
        end
        res_next.level = in_data.tlev;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= res_next;
    end
  end

  // An error result carries nothing but its code.
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.err != ERR_OK |->
      out_data.index == '0 && out_data.coord == '0 && out_data.level == '0)
    else $error("error result with payload");

  // Encode and decode results never mix.
  a_enc_dec: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.index != '0 |->
      out_data.coord == '0 && out_data.level == '0)
    else $error("index and coordinates both set");

endmodule

// File: src/quadtree_morton_index_codec.sv
// Top level of the quadtree Morton index encoder and decoder.
`timescale 1ns / 1ps
// Each accepted input word passes through three registered stages: check, align, pack.
// Throughput: one word per cycle unless the output stalls; each stage has its own valid bit and
// register, so an empty stage still takes a word while the output waits.
// Once all three stages hold words, a stall at the output holds them all;
// nothing is lost or repeated. Reset (synchronous, active high) clears the valid bits only.
module quadtree_morton_index_codec #(
  parameter int DIMENSION = qmic_pkg::DIMENSION_DEF,
  parameter int LEVEL_CAP = qmic_pkg::LEVEL_CAP_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // Input words.
  input  logic         s_tvalid,
  output logic         s_tready,
  // target_level[4:0], cell_level[9:5], coord_x[39:10], coord_y[69:40],
  // coord_z[99:70], morton_index[159:100]
  input  logic [159:0] s_tdata,
  // req_type[0]: 0 encode, 1 decode
  input  logic         s_tuser,
  // Result words.
  output logic         m_tvalid,
  input  logic         m_tready,
  // index_out[59:0], out_x[89:60], out_y[119:90], out_z[149:120],
  // out_level[154:150], error_code[157:155], zero[159:158]
  output logic [159:0] m_tdata
);
  import qmic_pkg::*;

  req_t req;
  chk_t chk;
  aln_t aln;
  res_t res;
  logic chk_valid, chk_ready;
  logic aln_valid, aln_ready;

  // Unpack the input word into its fields.
  assign req.req      = s_tuser;
  assign req.tlev     = s_tdata[4:0];
  assign req.clev     = s_tdata[9:5];
  assign req.coord[0] = s_tdata[39:10];
  assign req.coord[1] = s_tdata[69:40];
  assign req.coord[2] = s_tdata[99:70];
  assign req.idx      = s_tdata[159:100];

  // Stage one checks the request and records the error code.
  qmic_check #(
    .DIMENSION (DIMENSION),
    .LEVEL_CAP (LEVEL_CAP)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (req),
    .out_valid (chk_valid),
    .out_ready (chk_ready),
    .out_data  (chk)
  );

  // Stage two brings each axis's level bits down to the low end.
  qmic_align #(
    .DIMENSION (DIMENSION)
  ) u_align (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chk_valid),
    .in_ready  (chk_ready),
    .in_data   (chk),
    .out_valid (aln_valid),
    .out_ready (aln_ready),
    .out_data  (aln)
  );

  // Stage three interleaves for encode, shifts back up for decode, and
  // holds the result word until it is taken.
  qmic_pack #(
    .DIMENSION (DIMENSION)
  ) u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (aln_valid),
    .in_ready  (aln_ready),
    .in_data   (aln),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  assign m_tdata = {2'b00, res.err, res.level, res.coord[2], res.coord[1],
                    res.coord[0], res.index};

  // The input can only be held off by back pressure at the output.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back pressure");

endmodule

// File: sim/qmic_result_checker.sv
// Result checker for the Morton index codec: predicts each result word and compares it.
`timescale 1ns / 1ps
module qmic_result_checker #(
  parameter int DIMENSION = qmic_pkg::DIMENSION_DEF,
  parameter int LEVEL_CAP = qmic_pkg::LEVEL_CAP_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [159:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  output int           fail_count,
  output int           pending,
  output int           encodes_ok,
  output int           decodes_ok,
  output int           rejected
);
  import qmic_pkg::*;

  res_t results_due[$];

  // Expected result word for one request, following the encode and decode rules.
  function automatic res_t codec_result(logic decode, level_t tlev, level_t clev,
                                        coord_t cx, coord_t cy, coord_t cz, idx_t idx);
    res_t        r;
    err_t        err;
    coord_t      c [NUM_AXES];
    logic [63:0] align_mask;
    logic [63:0] top;
    logic [63:0] spread;
    bit          tlev_ok;
    r    = '0;
    err  = ERR_OK;
    c[0] = cx;
    c[1] = cy;
    c[2] = (DIMENSION == 3) ? cz : '0;
    tlev_ok = (int'(tlev) <= LEVEL_CAP) && (DIMENSION * int'(tlev) <= INDEX_BITS);
    if (!decode) begin
      if (int'(clev) > LEVEL_CAP) begin
        err = ERR_LEVEL;
      end else begin
        align_mask = (64'd1 << (COORD_BITS - int'(clev))) - 64'd1;
        for (int d = 0; d < DIMENSION; d++)
          if ((64'(c[d]) & align_mask) != 0 && err == ERR_OK) err = ERR_ALIGN;
        // A 30-bit coordinate can never reach the root length, so the
        // outside-root check has nothing to catch here.
        if (err == ERR_OK && !tlev_ok) err = ERR_LEVEL;
      end
      if (err == ERR_OK) begin
        for (int d = 0; d < DIMENSION; d++) begin
          top = 64'(c[d]) >> (COORD_BITS - int'(tlev));
          for (int i = 0; i < int'(tlev); i++) r.index[DIMENSION * i + d] = top[i];
        end
      end
    end else begin
      if (!tlev_ok) err = ERR_LEVEL;
      else if ((64'(idx) >> (DIMENSION * int'(tlev))) != 0) err = ERR_INDEX;
      if (err == ERR_OK) begin
        for (int d = 0; d < DIMENSION; d++) begin
          spread = '0;
          for (int i = 0; i < int'(tlev); i++) spread[i] = idx[DIMENSION * i + d];
          r.coord[d] = coord_t'(spread << (COORD_BITS - int'(tlev)));
        end
        r.level = tlev;
      end
    end
    r.err = err;
    return r;
  endfunction

  task automatic report_fail(string msg);
    $display("[%0t] check failed: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst) begin
      // Results first: a word cannot come out in the cycle it goes in.
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_fail($sformatf("result word with nothing expected: %h", m_tdata));
        end else begin
          want = results_due.pop_front();
          if (m_tdata[59:0] !== want.index)
            report_fail($sformatf("index_out %h, expected %h", m_tdata[59:0], want.index));
          if (m_tdata[89:60] !== want.coord[0])
            report_fail($sformatf("out_x %h, expected %h", m_tdata[89:60], want.coord[0]));
          if (m_tdata[119:90] !== want.coord[1])
            report_fail($sformatf("out_y %h, expected %h", m_tdata[119:90], want.coord[1]));
          if (m_tdata[149:120] !== want.coord[2])
            report_fail($sformatf("out_z %h, expected %h", m_tdata[149:120], want.coord[2]));
          if (m_tdata[154:150] !== want.level)
            report_fail($sformatf("out_level %0d, expected %0d", m_tdata[154:150], want.level));
          if (m_tdata[157:155] !== want.err)
            report_fail($sformatf("error_code %0d, expected %0d", m_tdata[157:155], want.err));
          if (m_tdata[159:158] !== 2'b00)
            report_fail($sformatf("padding bits %b, expected 00", m_tdata[159:158]));
        end
      end
      if (s_tvalid && s_tready) begin
        want = codec_result(s_tuser, s_tdata[4:0], s_tdata[9:5], s_tdata[39:10],
                            s_tdata[69:40], s_tdata[99:70], s_tdata[159:100]);
        results_due.push_back(want);
        if (want.err != ERR_OK) rejected++;
        else if (s_tuser) decodes_ok++;
        else encodes_ok++;
      end
    end
    pending <= results_due.size();
  end

endmodule

// File: sim/quadtree_morton_index_codec_tb.sv
// Testbench top for the Morton index codec: stimulus, handshake idling and verdict.
`timescale 1ns / 1ps
module quadtree_morton_index_codec_tb;
  import qmic_pkg::*;

  localparam int DIMENSION   = DIMENSION_DEF;
  localparam int LEVEL_CAP   = LEVEL_CAP_DEF;
  // Longest run of cycles without a single accepted word before giving up.
  // Gaps and stalls are bounded and the pipeline is three deep,
  // so this is far beyond any correct run.
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;
  localparam int RANDOM_WORDS = 1100;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // target_level[4:0], cell_level[9:5], coord_x[39:10], coord_y[69:40],
  // coord_z[99:70], morton_index[159:100]
  logic [159:0] s_tdata;
  // req_type[0]: 0 encode, 1 decode
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // index_out[59:0], out_x[89:60], out_y[119:90], out_z[149:120],
  // out_level[154:150], error_code[157:155], zero[159:158]
  logic [159:0] m_tdata;

  int fail_count;
  int pending;
  int encodes_ok;
  int decodes_ok;
  int rejected;
  int quiet_cycles;

  // Idling switches: the sender leaves gaps, the receiver stalls.
  bit tx_gaps;
  bit rx_stalls;

  quadtree_morton_index_codec #(
    .DIMENSION(DIMENSION),
    .LEVEL_CAP(LEVEL_CAP)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  qmic_result_checker #(
    .DIMENSION(DIMENSION),
    .LEVEL_CAP(LEVEL_CAP)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .fail_count(fail_count),
    .pending   (pending),
    .encodes_ok(encodes_ok),
    .decodes_ok(decodes_ok),
    .rejected  (rejected)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a run that stops moving words is a hang, whatever the cause.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d results outstanding.",
               QUIET_LIMIT, pending);
      $display("** quadtree_morton_index_codec: FAILED **");
      $finish;
    end
  end

  // Result side: ready stays high except for random stall bursts while enabled.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Offers one request word and returns at the edge where it is taken. Valid is
  // only lowered when a gap is inserted, so back-to-back words keep it high.
  task automatic send_word(logic decode, level_t tlev, level_t clev,
                           coord_t cx, coord_t cy, coord_t cz, idx_t idx);
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= decode;
    s_tdata  <= {idx, cz, cy, cx, clev, tlev};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic coord_t random_coord();
    return coord_t'($urandom);
  endfunction

  function automatic idx_t random_index();
    return idx_t'({$urandom, $urandom});
  endfunction

  // Clears the bits below the size of a cell at the given level.
  function automatic coord_t align_to(coord_t c, int lvl);
    return c & ~coord_t'((64'd1 << (COORD_BITS - lvl)) - 64'd1);
  endfunction

  // Mask of the index bits that a decode at this level may use.
  function automatic idx_t index_span(int lvl);
    if (DIMENSION * lvl >= INDEX_BITS) return '1;
    return idx_t'((64'd1 << (DIMENSION * lvl)) - 64'd1);
  endfunction

  initial begin
    int     pick;
    int     tl;
    int     cl;
    int     free_bit;
    idx_t   idx;
    coord_t x;
    coord_t y;
    coord_t z;

    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words: the corners of every field and each error path.
    // Root cell at level zero, index formed at level zero.
    send_word(1'b0, 5'd0, 5'd0, '0, '0, '0, '0);
    // Finest cell with every coordinate bit set, full-depth index.
    send_word(1'b0, 5'd30, 5'd30, '1, '1, '1, '0);
    // Finest cell, index taken at a coarse level: only the top bits survive.
    send_word(1'b0, 5'd5, 5'd30, 30'h2AAA_AAAA, 30'h1555_5555, '1, '1);
    // Coarse cell encoded at a finer level: the extra bits are zero.
    send_word(1'b0, 5'd30, 5'd2, 30'h3000_0000, 30'h1000_0000, '0, '0);
    // Cell level above the maximum wins over misaligned coordinates.
    send_word(1'b0, 5'd10, 5'd31, 30'h0000_0001, 30'h0000_0003, '0, '0);
    // Misaligned x, then misaligned y only.
    send_word(1'b0, 5'd10, 5'd1, 30'h0000_0001, '0, '0, '0);
    send_word(1'b0, 5'd10, 5'd1, '0, 30'h1FFF_FFFF, '0, '0);
    // Root cell with the top coordinate bit set is misaligned.
    send_word(1'b0, 5'd0, 5'd0, 30'h2000_0000, '0, '0, '0);
    // Well-formed cell but a target level beyond the maximum.
    send_word(1'b0, 5'd31, 5'd3, 30'h2000_0000, 30'h0800_0000, '0, '0);
    // z is ignored on a quadtree, misaligned or not.
    send_word(1'b0, 5'd4, 5'd4, 30'h1000_0000, 30'h3000_0000, 30'h0000_0001, '0);
    // Decode at level zero: only index zero fits.
    send_word(1'b1, 5'd0, 5'd0, '1, '1, '1, '0);
    send_word(1'b1, 5'd0, 5'd0, '0, '0, '0, 60'd1);
    // Decode of the all-ones index at full depth.
    send_word(1'b1, 5'd30, 5'd0, '0, '0, '0, '1);
    // Decode at a level beyond the maximum.
    send_word(1'b1, 5'd31, 5'd31, '0, '0, '0, '0);
    // Largest index that fits at level ten, then the first one that does not.
    send_word(1'b1, 5'd10, 5'd0, '0, '0, '0, index_span(10));
    send_word(1'b1, 5'd10, 5'd0, '0, '0, '0, 60'd1 << 20);
    // Only the top index bit set, one level short of full depth.
    send_word(1'b1, 5'd29, 5'd0, '0, '0, '0, 60'd1 << 59);
    // Alternating bit patterns split cleanly between the axes.
    send_word(1'b1, 5'd30, 5'd0, '0, '0, '0, 60'h555_5555_5555_5555);
    send_word(1'b1, 5'd30, 5'd0, '0, '0, '0, 60'hAAA_AAAA_AAAA_AAAA);
    send_word(1'b1, 5'd1, 5'd0, '0, '0, '0, 60'd3);

    // Random words. The idling pattern changes every hundred words so that
    // gaps and stalls land on every pipeline stage, with quiet stretches in
    // between; the final stretch runs with no idling at all.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        tx_gaps   = (n < RANDOM_WORDS - 150) && ((n / 100) % 4 inside {0, 1});
        rx_stalls = (n < RANDOM_WORDS - 150) && ((n / 100) % 4 inside {0, 2});
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // Well-formed encode: aligned coordinates at a usable level.
        cl = $urandom_range(0, LEVEL_CAP);
        tl = $urandom_range(0, LEVEL_CAP);
        x  = align_to(random_coord(), cl);
        y  = align_to(random_coord(), cl);
        z  = align_to(random_coord(), cl);
        send_word(1'b0, level_t'(tl), level_t'(cl), x, y, z, random_index());
      end else if (pick < 80) begin
        // Well-formed decode: the index fits the level.
        tl  = $urandom_range(0, LEVEL_CAP);
        idx = random_index() & index_span(tl);
        send_word(1'b1, level_t'(tl), level_t'($urandom_range(0, 31)),
                  random_coord(), random_coord(), random_coord(), idx);
      end else if (pick < 90) begin
        // Encode noise: any levels, unaligned coordinates.
        send_word(1'b0, level_t'($urandom_range(0, 31)), level_t'($urandom_range(0, 31)),
                  random_coord(), random_coord(), random_coord(), random_index());
      end else begin
        // Decode noise: one stray bit above the bound, or a bad level.
        tl  = $urandom_range(0, 31);
        idx = random_index() & index_span(tl);
        if (DIMENSION * tl < INDEX_BITS) begin
          free_bit = $urandom_range(DIMENSION * tl, INDEX_BITS - 1);
          idx[free_bit] = 1'b1;
        end
        send_word(1'b1, level_t'(tl), level_t'($urandom_range(0, 31)),
                  random_coord(), random_coord(), random_coord(), idx);
      end
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d encodes and %0d decodes accepted, %0d flagged.",
             encodes_ok + decodes_ok + rejected, encodes_ok, decodes_ok, rejected);
    $display("Stimulus mixed level, alignment and index-bound errors with random stalls.");
    if (fail_count == 0) begin
      $display("** quadtree_morton_index_codec: PASSED **");
    end else begin
      $display("** quadtree_morton_index_codec: FAILED **");
    end
    $finish;
  end

endmodule
